// File: hdl/dsi_pkg.sv
package dsi_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int TIME_W     = 17;
    localparam int VAL_W      = 32;
    localparam int DIFF_W     = VAL_W + 1;
    localparam int NUM_W      = DIFF_W + TIME_W;
    localparam int STEP_W     = $clog2(NUM_W + 1);

    localparam int SEC_PER_HOUR = 3600;
    localparam int SEC_PER_MIN  = 60;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_EVAL  = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] t;
        logic [VAL_W-1:0]  v;
        logic              ramp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ABS,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

endpackage

// File: hdl/dsi_ram.sv
module dsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/daily_schedule_interpolator.sv
// Piecewise-linear daily schedule. A write item (req_type 0) loads one
// breakpoint if point_index is below the point count and gives no result;
// busy stays low. An evaluate item (req_type 1) gives exactly one result,
// pulsed on done for one cycle with value; the receiver cannot stall, so
// capture it then. With no points in use the result comes in the cycle after
// the item is accepted. Otherwise the breakpoint memory is read one entry per
// cycle and the scan stops at the first matching point. A ramp adds an abs,
// a multiply, a bit-serial divide and a final add. busy is high from the
// cycle after an evaluate item with points in use is accepted until done. A
// cfg_we write sets the point count, saturated at MAX_POINTS, and clears the
// entries past it; the new count is registered.
module daily_schedule_interpolator
    import dsi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     req_type,
    input  logic [4:0]               hour,
    input  logic [5:0]               minute,
    input  logic [5:0]               second,
    input  logic [IDX_W-1:0]         point_index,
    input  logic [TIME_W-1:0]        point_time,
    input  logic signed [VAL_W-1:0]  point_value,
    input  logic                     point_ramp,
    input  logic                     cfg_we,
    input  logic [CNT_W-1:0]         cfg_wdata,
    output logic                     done,
    output logic signed [VAL_W-1:0]  value
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]      count_reg;
    logic [MAX_POINTS-1:0] valid_reg;
    logic [CNT_W-1:0]      scan_reg, scan_next;
    logic                  chk_vld_reg;
    logic [IDX_W-1:0]      chk_idx_reg;
    logic                  chk_ok_reg;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  done_reg, done_next;

    logic [TIME_W-1:0]     now_reg, now_next;
    entry_t                prev_reg, prev_next;
    logic [VAL_W-1:0]      v0_reg, v0_next;
    logic [VAL_W-1:0]      vi_reg, vi_next;
    logic [DIFF_W-1:0]     diff_reg, diff_next;
    logic [TIME_W-1:0]     el_reg, el_next;
    logic [TIME_W-1:0]     dt_reg, dt_next;
    logic                  neg_reg, neg_next;
    logic [DIFF_W-1:0]     mag_reg, mag_next;
    logic [NUM_W-1:0]      num_reg, num_next;
    logic [TIME_W:0]       rem_reg, rem_next;
    logic [VAL_W-1:0]      held_reg, held_next;

    logic                  accept;
    logic                  ram_we;
    logic                  ram_re;
    entry_t                ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;
    entry_t                cur;
    logic [CNT_W-1:0]      cfg_count;
    logic [TIME_W-1:0]     now_calc;
    logic [NUM_W-1:0]      prod;
    logic [TIME_W:0]       rem_shift;
    logic                  rem_ge;
    logic [VAL_W-1:0]      quot;
    logic                  last_chk;
    logic                  hit_prev;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign value  = held_reg;

    assign ram_we    = accept && (req_type == REQ_WRITE)
                       && ({1'b0, point_index} < count_reg);
    assign ram_wdata = '{t: point_time, v: point_value, ramp: point_ramp};
    assign ram_re    = (state_reg == ST_SCAN) && (scan_reg < count_reg);

    dsi_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_points (
        .clk   (clk),
        .we    (ram_we),
        .waddr (point_index),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (scan_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // An entry never written since reset or cleared by a count write reads as zero.
    assign cur = chk_ok_reg ? entry_t'(ram_rdata) : '0;

    assign cfg_count = (cfg_wdata > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : cfg_wdata;

    assign now_calc = TIME_W'(hour) * TIME_W'(SEC_PER_HOUR)
                    + TIME_W'(minute) * TIME_W'(SEC_PER_MIN)
                    + TIME_W'(second);

    assign prod = NUM_W'(mag_reg) * NUM_W'(el_reg);

    assign rem_shift = {rem_reg[TIME_W-1:0], num_reg[NUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, dt_reg});
    assign quot      = num_reg[VAL_W-1:0];

    assign last_chk = ({1'b0, chk_idx_reg} == CNT_W'(count_reg - 1'b1));
    assign hit_prev = (chk_idx_reg != '0) && (now_reg > prev_reg.t) && (now_reg <= cur.t);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            valid_reg   <= '0;
            scan_reg    <= '0;
            chk_vld_reg <= 1'b0;
            chk_idx_reg <= '0;
            chk_ok_reg  <= 1'b0;
            step_reg    <= '0;
            done_reg    <= 1'b0;
            held_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            scan_reg    <= scan_next;
            chk_vld_reg <= ram_re;
            chk_idx_reg <= scan_reg[IDX_W-1:0];
            chk_ok_reg  <= valid_reg[scan_reg[IDX_W-1:0]];
            step_reg    <= step_next;
            done_reg    <= done_next;
            held_reg    <= held_next;
            if (ram_we)
            begin
                valid_reg[point_index] <= 1'b1;
            end
            if (cfg_we)
            begin
                count_reg <= cfg_count;
                for (int i = 0; i < MAX_POINTS; i++)
                begin
                    if (CNT_W'(i) >= cfg_count)
                    begin
                        valid_reg[i] <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg  <= now_next;
        prev_reg <= prev_next;
        v0_reg   <= v0_next;
        vi_reg   <= vi_next;
        diff_reg <= diff_next;
        el_reg   <= el_next;
        dt_reg   <= dt_next;
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
    end

    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        held_next  = held_reg;
        now_next   = now_reg;
        prev_next  = prev_reg;
        v0_next    = v0_reg;
        vi_next    = vi_reg;
        diff_next  = diff_reg;
        el_next    = el_reg;
        dt_next    = dt_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == REQ_EVAL))
                begin
                    now_next  = now_calc;
                    scan_next = '0;
                    if (count_reg == '0)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (ram_re)
                begin
                    scan_next = scan_reg + 1'b1;
                end
                if (chk_vld_reg)
                begin
                    prev_next = cur;
                    if (chk_idx_reg == '0)
                    begin
                        v0_next = cur.v;
                    end
                    if (hit_prev)
                    begin
                        if (prev_reg.ramp)
                        begin
                            vi_next    = prev_reg.v;
                            diff_next  = {cur.v[VAL_W-1], cur.v}
                                       - {prev_reg.v[VAL_W-1], prev_reg.v};
                            el_next    = now_reg - prev_reg.t;
                            dt_next    = cur.t - prev_reg.t;
                            state_next = ST_ABS;
                        end
                        else
                        begin
                            held_next  = prev_reg.v;
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else if (last_chk)
                    begin
                        // Past the last point: hold it; otherwise fall back to point 0.
                        if (now_reg > cur.t)
                        begin
                            held_next = cur.v;
                        end
                        else
                        begin
                            held_next = (chk_idx_reg == '0) ? cur.v : v0_reg;
                        end
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_ABS:
            begin
                neg_next   = diff_reg[DIFF_W-1];
                mag_next   = diff_reg[DIFF_W-1] ? (~diff_reg + 1'b1) : diff_reg;
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                num_next   = prod;
                rem_next   = '0;
                step_next  = STEP_W'(NUM_W);
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                // Restoring divide: one quotient bit per cycle, shifted into num_reg.
                rem_next  = rem_ge ? (rem_shift - {1'b0, dt_reg}) : rem_shift;
                num_next  = {num_reg[NUM_W-2:0], rem_ge};
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                held_next  = neg_reg ? (vi_reg - quot) : (vi_reg + quot);
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sim/daily_schedule_interpolator_tb.sv
module daily_schedule_interpolator_tb
    import dsi_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1200;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int END_SETTLE   = 80;
    localparam int CFG_SETTLE   = 4;
    localparam int HOUR_MAX     = 31;
    localparam int MS_MAX       = 63;
    localparam int COUNT_MAX    = 2**CNT_W - 1;
    localparam int TIME_MAX     = 2**TIME_W - 1;

    class sched_board;
        logic [TIME_W-1:0] pt_time [MAX_POINTS];
        logic [VAL_W-1:0]  pt_val  [MAX_POINTS];
        logic              pt_ramp [MAX_POINTS];
        logic [VAL_W-1:0]  last_value;
        int unsigned       active_points;
        logic [VAL_W-1:0]  pending_values [$];
        int                errors;
        int                accepted_items;

        function new();
            for (int i = 0; i < MAX_POINTS; i++)
            begin
                pt_time[i] = '0;
                pt_val[i]  = '0;
                pt_ramp[i] = 1'b0;
            end
            last_value     = '0;
            active_points  = 0;
            errors         = 0;
            accepted_items = 0;
        endfunction

        // Saturate the count and clear every slot past it.
        function void set_count(logic [CNT_W-1:0] code);
            active_points = (code > MAX_POINTS) ? MAX_POINTS : code;
            for (int i = active_points; i < MAX_POINTS; i++)
            begin
                pt_time[i] = '0;
                pt_val[i]  = '0;
                pt_ramp[i] = 1'b0;
            end
        endfunction

        function logic [VAL_W-1:0] scheduled_value(int unsigned now);
            longint v0, v1, span, elapsed, q;
            for (int i = 0; i < active_points; i++)
            begin
                if (now > pt_time[i])
                begin
                    if (i + 1 == active_points)
                        return pt_val[i];
                    if (now <= pt_time[i+1])
                    begin
                        if (!pt_ramp[i])
                            return pt_val[i];
                        v0      = longint'(signed'(pt_val[i]));
                        v1      = longint'(signed'(pt_val[i+1]));
                        span    = longint'(pt_time[i+1]) - longint'(pt_time[i]);
                        elapsed = longint'(now) - longint'(pt_time[i]);
                        // SV division truncates toward zero
                        q = v0 + ((v1 - v0) * elapsed) / span;
                        return q[VAL_W-1:0];
                    end
                end
            end
            return pt_val[0];
        endfunction

        function void note_item(logic rt, logic [4:0] h, logic [5:0] m, logic [5:0] s,
                                logic [IDX_W-1:0] idx, logic [TIME_W-1:0] t,
                                logic [VAL_W-1:0] v, logic r);
            int unsigned now;
            if (rt == REQ_WRITE)
            begin
                // drop writes outside the table in use
                if (idx < active_points)
                begin
                    pt_time[idx] = t;
                    pt_val[idx]  = v;
                    pt_ramp[idx] = r;
                    accepted_items++;
                end
            end
            else
            begin
                now = int'(h) * SEC_PER_HOUR + int'(m) * SEC_PER_MIN + int'(s);
                if (active_points != 0)
                    last_value = scheduled_value(now);
                pending_values = {pending_values, last_value};
                accepted_items++;
            end
        endfunction

        function void check_value(logic [VAL_W-1:0] got);
            logic [VAL_W-1:0] want;
            if (pending_values.size() == 0)
            begin
                $error("value: expected none, actual %0d", $signed(got));
                errors++;
            end
            else
            begin
                want = pending_values.pop_front();
                if (want !== got)
                begin
                    $error("value: expected %0d, actual %0d", $signed(want), $signed(got));
                    errors++;
                end
            end
        endfunction
    endclass

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    start       = 1'b0;
    logic                    busy;
    logic                    req_type    = REQ_WRITE;
    logic [4:0]              hour        = '0;
    logic [5:0]              minute      = '0;
    logic [5:0]              second      = '0;
    logic [IDX_W-1:0]        point_index = '0;
    logic [TIME_W-1:0]       point_time  = '0;
    logic signed [VAL_W-1:0] point_value = '0;
    logic                    point_ramp  = 1'b0;
    logic                    cfg_we      = 1'b0;
    logic [CNT_W-1:0]        cfg_wdata   = '0;
    logic                    done;
    logic signed [VAL_W-1:0] value;
    int                      cycles      = 0;

    sched_board board = new();

    daily_schedule_interpolator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .hour        (hour),
        .minute      (minute),
        .second      (second),
        .point_index (point_index),
        .point_time  (point_time),
        .point_value (point_value),
        .point_ramp  (point_ramp),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .done        (done),
        .value       (value)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                board.set_count(cfg_wdata);
            if (start && !busy)
                board.note_item(req_type, hour, minute, second, point_index,
                                point_time, point_value, point_ramp);
            if (done)
                board.check_value(value);
        end
    end

    // Hold start high until the block takes the item; leave it high on return.
    task automatic send_item(input int pct, input logic rt, input logic [4:0] h,
                             input logic [5:0] m, input logic [5:0] s,
                             input logic [IDX_W-1:0] idx, input logic [TIME_W-1:0] t,
                             input logic [VAL_W-1:0] v, input logic r);
        while ($urandom_range(0, 99) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        req_type    <= rt;
        hour        <= h;
        minute      <= m;
        second      <= s;
        point_index <= idx;
        point_time  <= t;
        point_value <= v;
        point_ramp  <= r;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic send_write(input int pct, input int idx, input int unsigned t,
                              input logic [VAL_W-1:0] v, input logic r);
        send_item(pct, REQ_WRITE, 5'($urandom_range(0, HOUR_MAX)),
                  6'($urandom_range(0, MS_MAX)), 6'($urandom_range(0, MS_MAX)),
                  IDX_W'(idx), TIME_W'(t), v, r);
    endtask

    task automatic send_eval(input int pct, input int h, input int m, input int s);
        send_item(pct, REQ_EVAL, 5'(h), 6'(m), 6'(s),
                  IDX_W'($urandom_range(0, MAX_POINTS - 1)),
                  TIME_W'($urandom_range(0, TIME_MAX)), $urandom(),
                  1'($urandom_range(0, 1)));
    endtask

    // Pause until every expected value is in and the block is quiet.
    task automatic wait_idle(input int settle);
        start <= 1'b0;
        do
            @(posedge clk);
        while (board.pending_values.size() != 0 || busy);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_count(input int code);
        cfg_we    <= 1'b1;
        cfg_wdata <= CNT_W'(code);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_round(input int pct);
        int unsigned      stamp [MAX_POINTS];
        int unsigned      code, used, t, now, j;
        logic [VAL_W-1:0] v;
        wait_idle(CFG_SETTLE);
        case ($urandom_range(0, 15))
            0:       code = 0;
            1:       code = MAX_POINTS;
            2:       code = $urandom_range(MAX_POINTS + 1, COUNT_MAX);
            3:       code = $urandom_range(7, MAX_POINTS - 1);
            default: code = $urandom_range(1, 6);
        endcase
        write_count(code);
        used = (code > MAX_POINTS) ? MAX_POINTS : code;

        // mostly ascending breakpoints, with an occasional repeated time
        t = $urandom_range(0, 7200);
        for (int i = 0; i < MAX_POINTS; i++)
        begin
            stamp[i] = t;
            if ($urandom_range(0, 7) != 0)
                t += $urandom_range(1, 80000 / (used + 1));
        end

        if ($urandom_range(0, 5) != 0)
        begin
            for (int i = 0; i < used; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    stamp[i] = $urandom_range(0, TIME_MAX);
                case ($urandom_range(0, 7))
                    0:       v = {1'b1, {(VAL_W-1){1'b0}}};
                    1:       v = {1'b0, {(VAL_W-1){1'b1}}};
                    default: v = $urandom();
                endcase
                send_write(pct, i, stamp[i], v, 1'($urandom_range(0, 1)));
            end
        end
        if (used < MAX_POINTS && $urandom_range(0, 3) == 0)
            send_write(pct, $urandom_range(used, MAX_POINTS - 1), $urandom_range(0, TIME_MAX),
                       $urandom(), 1'($urandom_range(0, 1)));

        repeat ($urandom_range(4, 16))
        begin
            if ($urandom_range(0, 9) == 0)
                send_write(pct, $urandom_range(0, MAX_POINTS - 1), $urandom_range(0, TIME_MAX),
                           $urandom(), 1'($urandom_range(0, 1)));
            else if (used != 0 && $urandom_range(0, 9) < 7)
            begin
                // aim at and around a breakpoint
                j = $urandom_range(0, used - 1);
                case ($urandom_range(0, 3))
                    0:       now = stamp[j];
                    1:       now = stamp[j] + 1;
                    2:       now = (stamp[j] == 0) ? 0 : stamp[j] - 1;
                    default: now = stamp[j] + $urandom_range(0, 3000);
                endcase
                if (now < (HOUR_MAX + 1) * SEC_PER_HOUR)
                    send_eval(pct, now / SEC_PER_HOUR, now % SEC_PER_HOUR / SEC_PER_MIN,
                              now % SEC_PER_MIN);
                else
                    send_eval(pct, HOUR_MAX, $urandom_range(0, MS_MAX),
                              $urandom_range(0, MS_MAX));
            end
            else
                send_eval(pct, $urandom_range(0, HOUR_MAX), $urandom_range(0, MS_MAX),
                          $urandom_range(0, MS_MAX));
        end
    endtask

    initial
    begin
        int base;
        int progress;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty table: hold the last value, drop writes
        wait_idle(CFG_SETTLE);
        write_count(0);
        send_eval(0, 0, 0, 0);
        send_write(0, 0, 100, 32'h1234_5678, 1'b1);
        send_eval(0, 12, 0, 0);

        // three points: before the first, on it, ramp across full range,
        // step, last point, out-of-range clock fields
        wait_idle(CFG_SETTLE);
        write_count(3);
        send_write(0, 0, 3600, 32'h8000_0000, 1'b1);
        send_write(0, 1, 7200, 32'h7FFF_FFFF, 1'b0);
        send_write(0, 2, 86399, 32'hFFFF_0000, 1'b1);
        send_write(0, 3, 0, 32'h0000_007B, 1'b1);
        send_eval(0, 0, 0, 0);
        send_eval(0, 1, 0, 0);
        send_eval(0, 1, 0, 1);
        send_eval(0, 1, 30, 0);
        send_eval(0, 2, 0, 0);
        send_eval(0, 2, 0, 1);
        send_eval(0, 23, 59, 59);
        send_eval(0, HOUR_MAX, MS_MAX, MS_MAX);

        // count saturates; top slot with the widest time
        wait_idle(CFG_SETTLE);
        write_count(COUNT_MAX);
        send_write(0, MAX_POINTS - 1, TIME_MAX, 32'h0001_0000, 1'b1);
        send_write(0, MAX_POINTS - 2, 0, 32'hDEAD_BEEF, 1'b1);
        send_eval(0, HOUR_MAX, MS_MAX, MS_MAX);
        send_eval(0, 0, 0, 1);

        // back to empty, then one point left after the clear
        wait_idle(CFG_SETTLE);
        write_count(0);
        send_eval(0, 5, 5, 5);
        wait_idle(CFG_SETTLE);
        write_count(1);
        send_eval(0, 0, 0, 0);
        send_eval(0, 23, 0, 0);

        base = board.accepted_items;
        while (board.accepted_items - base < RANDOM_ITEMS)
        begin
            progress = board.accepted_items - base;
            if (progress < RANDOM_ITEMS / 3)
                run_round(38);
            else if (progress < 2 * RANDOM_ITEMS / 3)
                run_round(56);
            else
                run_round(0);
        end

        wait_idle(END_SETTLE);
        if (board.errors == 0 && board.pending_values.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
hdl/dsi_pkg.sv
hdl/dsi_ram.sv
hdl/daily_schedule_interpolator.sv
sim/daily_schedule_interpolator_tb.sv
